// ===== src/dmls_pkg.sv =====
// Package for the data memory load/store stage: opcodes, access decode and word layout.
`default_nettype none
package dmls_pkg;

    localparam logic [5:0] OP_LW  = 6'h23;
    localparam logic [5:0] OP_LH  = 6'h21;
    localparam logic [5:0] OP_LHU = 6'h25;
    localparam logic [5:0] OP_LB  = 6'h20;
    localparam logic [5:0] OP_LBU = 6'h24;
    localparam logic [5:0] OP_SW  = 6'h2B;
    localparam logic [5:0] OP_SH  = 6'h29;
    localparam logic [5:0] OP_SB  = 6'h28;

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    typedef struct packed {
        logic is_word;
        logic is_half;
        logic is_byte;
        logic is_store;
        logic is_signed;
    } access_t;

    function automatic access_t decode_op(input logic [5:0] op);
        access_t acc;
        acc = '0;
        case (op)
            OP_LW:
            begin
                acc.is_word = 1'b1;
            end
            OP_SW:
            begin
                acc.is_word  = 1'b1;
                acc.is_store = 1'b1;
            end
            OP_LH:
            begin
                acc.is_half   = 1'b1;
                acc.is_signed = 1'b1;
            end
            OP_LHU:
            begin
                acc.is_half = 1'b1;
            end
            OP_SH:
            begin
                acc.is_half  = 1'b1;
                acc.is_store = 1'b1;
            end
            OP_LB:
            begin
                acc.is_byte   = 1'b1;
                acc.is_signed = 1'b1;
            end
            OP_LBU:
            begin
                acc.is_byte = 1'b1;
            end
            OP_SB:
            begin
                acc.is_byte  = 1'b1;
                acc.is_store = 1'b1;
            end
            default:
            begin
                acc = '0;
            end
        endcase
        return acc;
    endfunction

endpackage
`default_nettype wire

// ===== src/data_memory_load_store_stage.sv =====
// Memory stage of a MIPS pipeline: big-endian byte-addressed data memory, loads and stores.
//
// Input channel s_*: one word per instruction (opcode, address, store bytes, carried
// value, destination register) with bubble and halt flags in s_tuser. Output channel
// m_*: one word per input word, carrying the loaded or carried value, the destination
// register and the overflow and misalignment flags in m_tuser.
// The memory is held as four byte-lane RAMs of MEM_BYTES/4 rows (rounded up); an
// aligned access touches one row. The RAM address is taken from the input port at the
// accepting edge, the RAM registers the read data, and the result is formed from it
// into the output register once that register is free. The stage takes no new word
// until the result of the last one has been formed.
// One access is in flight at a time, so a store followed by a load needs no bypass.
// The output register decouples the sides: while a result waits on m_tready the next
// word is still accepted, and the stage holds in its result state only when a second
// result is ready before the first is taken.
// After reset the stage zeroes the memory, one row per cycle, over all ceil(MEM_BYTES/4)
// rows; s_tready stays low during that pass.
`default_nettype none
module data_memory_load_store_stage #(
    parameter int MEM_BYTES = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // req_type[5:0], mem_addr[37:6], store_b0[45:38], store_b1[53:46],
    // store_b2[61:54], store_b3[69:62], carried_value[101:70], dest_reg[106:102]
    input  wire logic [dmls_pkg::IN_DATA_W-1:0]    s_tdata,
    // is_bubble[0], is_halt[1]
    input  wire logic [dmls_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // result_value[31:0], result_reg[36:32]
    output logic      [dmls_pkg::OUT_DATA_W-1:0]   m_tdata,
    // addr_overflow[0], misaligned[1]
    output logic      [dmls_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int WORDS = (MEM_BYTES + 3) / 4;
    localparam int AW    = $clog2(WORDS);
    localparam logic [31:0] LIM_WORD = 32'(MEM_BYTES - 4);
    localparam logic [31:0] LIM_HALF = 32'(MEM_BYTES - 2);
    localparam logic [31:0] LIM_BYTE = 32'(MEM_BYTES - 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOAD  = 3'b100
    } state_t;

    // input fields
    logic [5:0]        req_type;
    logic signed [31:0] mem_addr;
    logic [7:0]        store_b0;
    logic [7:0]        store_b1;
    logic [7:0]        store_b2;
    logic [7:0]        store_b3;
    logic [31:0]       carried_value;
    logic [4:0]        dest_reg;
    logic              is_bubble;
    logic              is_halt;

    assign req_type      = s_tdata[5:0];
    assign mem_addr      = s_tdata[37:6];
    assign store_b0      = s_tdata[45:38];
    assign store_b1      = s_tdata[53:46];
    assign store_b2      = s_tdata[61:54];
    assign store_b3      = s_tdata[69:62];
    assign carried_value = s_tdata[101:70];
    assign dest_reg      = s_tdata[106:102];
    assign is_bubble     = s_tuser[0];
    assign is_halt       = s_tuser[1];

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;

    dmls_pkg::access_t acc_reg;
    logic              ok_reg;
    logic              ovf_reg;
    logic              mis_reg;
    logic [1:0]        lo_reg;
    logic [31:0]       carry_reg;
    logic [4:0]        dest_hold_reg;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_value_reg;
    logic [4:0]        out_reg_reg;
    logic              out_ovf_reg;
    logic              out_mis_reg;

    dmls_pkg::access_t acc;
    logic              ovf;
    logic              mis;
    logic              acc_ok;
    logic              s_fire;
    logic              out_free;
    logic              form;
    logic [31:0]       uaddr;

    logic [3:0]        ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata [4];
    logic [7:0]        ram_rdata [4];
    logic [31:0]       load_value;

    assign uaddr = mem_addr;

    always_comb
    begin
        acc = '0;
        if (!is_bubble && !is_halt)
        begin
            acc = dmls_pkg::decode_op(req_type);
        end
    end

    // sign bit set means a negative address: always out of range
    always_comb
    begin
        ovf = 1'b0;
        mis = 1'b0;
        if (acc.is_word)
        begin
            ovf = uaddr[31] || ({1'b0, uaddr[30:0]} > LIM_WORD);
            mis = (uaddr[1:0] != 2'b00);
        end
        else if (acc.is_half)
        begin
            ovf = uaddr[31] || ({1'b0, uaddr[30:0]} > LIM_HALF);
            mis = uaddr[0];
        end
        else if (acc.is_byte)
        begin
            ovf = uaddr[31] || ({1'b0, uaddr[30:0]} > LIM_BYTE);
        end
    end

    assign acc_ok   = (acc.is_word || acc.is_half || acc.is_byte) && !ovf && !mis;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign form     = (state_reg == ST_LOAD) && out_free;

    // RAM port: clearing pass, else the accepted access
    always_comb
    begin
        ram_we       = 4'b0000;
        ram_re       = 1'b0;
        ram_addr     = uaddr[AW+1:2];
        ram_wdata[0] = store_b0;
        ram_wdata[1] = acc.is_byte ? store_b0 : store_b1;
        ram_wdata[2] = acc.is_word ? store_b2 : store_b0;
        ram_wdata[3] = acc.is_word ? store_b3 : (acc.is_half ? store_b1 : store_b0);
        if (state_reg == ST_CLEAR)
        begin
            ram_we   = 4'b1111;
            ram_addr = clr_cnt_reg;
            for (int k = 0; k < 4; k++)
            begin
                ram_wdata[k] = 8'h00;
            end
        end
        else if (s_fire && acc_ok)
        begin
            if (acc.is_store)
            begin
                if (acc.is_word)
                begin
                    ram_we = 4'b1111;
                end
                else if (acc.is_half)
                begin
                    ram_we = uaddr[1] ? 4'b1100 : 4'b0011;
                end
                else
                begin
                    ram_we = 4'b0001 << uaddr[1:0];
                end
            end
            else
            begin
                ram_re = 1'b1;
            end
        end
    end

    // lane 0 holds the byte at the lowest address of a row (most significant)
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        dmls_ram #(
            .WIDTH(8),
            .DEPTH(WORDS)
        ) u_ram (
            .clk  (clk),
            .we   (ram_we[k]),
            .re   (ram_re),
            .addr (ram_addr),
            .wdata(ram_wdata[k]),
            .rdata(ram_rdata[k])
        );
    end

    always_comb
    begin
        logic [15:0] half;
        logic [7:0]  bval;
        half = lo_reg[1] ? {ram_rdata[2], ram_rdata[3]} : {ram_rdata[0], ram_rdata[1]};
        bval = ram_rdata[lo_reg];
        if (acc_reg.is_word)
        begin
            load_value = {ram_rdata[0], ram_rdata[1], ram_rdata[2], ram_rdata[3]};
        end
        else if (acc_reg.is_half)
        begin
            load_value = {{16{acc_reg.is_signed && half[15]}}, half};
        end
        else
        begin
            load_value = {{24{acc_reg.is_signed && bval[7]}}, bval};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the accepted item while its read completes
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            acc_reg       <= acc;
            ok_reg        <= acc_ok;
            ovf_reg       <= ovf;
            mis_reg       <= mis;
            lo_reg        <= uaddr[1:0];
            carry_reg     <= carried_value;
            dest_hold_reg <= dest_reg;
        end
        if (form)
        begin
            out_value_reg <= (ok_reg && !acc_reg.is_store) ? load_value : carry_reg;
            out_reg_reg   <= dest_hold_reg;
            out_ovf_reg   <= ovf_reg;
            out_mis_reg   <= mis_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg_reg, out_value_reg};
    assign m_tuser  = {out_mis_reg, out_ovf_reg};

    a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == ST_LOAD))
        else $error("accepted word did not move to the result state");

    a_no_write_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (ram_we == 4'b0000) && !ram_re)
        else $error("RAM accessed while read data is pending");

    a_flagged_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && (ram_we != 4'b0000)) |-> (!ovf && !mis && acc.is_store))
        else $error("RAM written by a flagged or non-store access");

    a_result_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        form |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("formed result not offered on the output");

endmodule
`default_nettype wire

// ===== src/dmls_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module dmls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire
